### src/pds_pkg.sv
// Shared types, constants and codes of the pairwise distance sum block.
`timescale 1ns / 1ps

package pds_pkg;

	// Default sizes of the stores
	localparam int PDS_MAX_ELEMENTS = 256;
	localparam int PDS_MAX_GENES    = 64;
	localparam int PDS_DIST_DEPTH   = 32640;

	// Fixed field widths
	localparam int ADDR_W    = 15;
	localparam int DIST_W    = 32;
	localparam int GENE_W    = 8;
	localparam int COUNT_W   = 9;
	localparam int SUM_W     = 48;
	localparam int GCOUNT_W  = 7;
	localparam int ERR_W     = 2;

	// Packed index arithmetic: products of an 8-bit gene and a 9-bit count
	localparam int PROD_W = 17;
	localparam int IDX_W  = 19;

	localparam logic [COUNT_W-1:0] ELEM_COUNT_RESET = 9'd256;

	// Pipeline stages between a pair issue and the sum update
	localparam int DRAIN_CYCLES = 3;
	localparam int DRAIN_W      = 2;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_GENE = 1'b1;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAIR,
		ST_DRAIN,
		ST_FINISH,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;  // input transfer this cycle
		logic issue;    // start one pair lookup
		logic commit;   // store gene or note error
		logic emit;     // load result register, clear subset
	} pds_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_gene;    // presented item is a gene command
		logic in_pairs;   // presented gene is valid and has earlier genes
		logic pair_last;  // current pair index is the final stored gene
		logic last;       // captured gene closes the subset
	} pds_status_t;

endpackage

### src/pds_ctrl.sv
// Controller state machine: sequences capture, pair lookups, drain, commit and result.
`timescale 1ns / 1ps

module pds_ctrl import pds_pkg::*; #(
	parameter int MAX_GENES = PDS_MAX_GENES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        out_ready,
	input  pds_status_t status,
	output logic        in_ready,
	output logic        out_valid,
	output pds_cmd_t    cmd,
	output logic [((MAX_GENES > 1) ? $clog2(MAX_GENES) : 1)-1:0] pair_idx
);

	localparam int GW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;

	state_t             state_q, state_d;
	logic [GW-1:0]      k_q;
	logic [DRAIN_W-1:0] drain_q;
	logic               out_valid_q;
	logic               accept;
	logic               slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign pair_idx  = k_q;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.in_gene) begin
					state_d = status.in_pairs ? ST_PAIR : ST_FINISH;
				end
			end
			ST_PAIR: begin
				if (status.pair_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = status.last ? ST_RESULT : ST_IDLE;
			end
			ST_RESULT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.capture = accept;
		cmd.issue   = (state_q == ST_PAIR);
		cmd.commit  = (state_q == ST_FINISH);
		cmd.emit    = (state_q == ST_RESULT) && slot_free;
	end

	// State, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + GW'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + DRAIN_W'(1);
			end else begin
				drain_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/pds_datapath.sv
// Datapath: distance and gene stores, packed index pipeline, running sum and result register.
`timescale 1ns / 1ps

module pds_datapath import pds_pkg::*; #(
	parameter int MAX_ELEMENTS = PDS_MAX_ELEMENTS,
	parameter int MAX_GENES    = PDS_MAX_GENES,
	parameter int DIST_DEPTH   = PDS_DIST_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic                command,
	input  logic [ADDR_W-1:0]   dist_address,
	input  logic [DIST_W-1:0]   dist_value,
	input  logic [GENE_W-1:0]   gene,
	input  logic                last,
	input  pds_cmd_t            cmd,
	input  logic [((MAX_GENES > 1) ? $clog2(MAX_GENES) : 1)-1:0] pair_idx,
	output pds_status_t         status,
	output logic [SUM_W-1:0]    fitness_sum,
	output logic [GCOUNT_W-1:0] genes_counted,
	output logic [ERR_W-1:0]    error_code
);

	localparam int GW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
	localparam int CW = $clog2(MAX_GENES + 1);
	localparam int AW = (DIST_DEPTH > 1) ? $clog2(DIST_DEPTH) : 1;

	logic [DIST_W-1:0] dist_mem [DIST_DEPTH];
	logic [GENE_W-1:0] gene_mem [MAX_GENES];

	logic [COUNT_W-1:0]  element_count_q;
	logic [COUNT_W-1:0]  n_eff;
	logic [CW-1:0]       gene_total_q;
	logic [SUM_W-1:0]    sum_q;
	logic [ERR_W-1:0]    err_flags_q;
	logic [GENE_W-1:0]   gene_q;
	logic                last_q;
	logic [ERR_W-1:0]    err_q;

	logic                in_oor;
	logic                in_full;
	logic [31:0]         load_addr;

	logic                valid_s1;
	logic [GENE_W-1:0]   stored_s1;
	logic                valid_s2;
	logic                same_s2;
	logic [PROD_W-1:0]   prod_a_s2;
	logic [PROD_W-1:0]   prod_b_s2;
	logic [GENE_W-1:0]   diff_s2;
	logic                valid_s3;
	logic                use_s3;
	logic [DIST_W-1:0]   dist_s3;

	logic [GENE_W-1:0]   lo;
	logic [GENE_W-1:0]   hi;
	logic [IDX_W-1:0]    idx;
	logic [31:0]         idx_ext;
	logic                idx_ok;
	logic [SUM_W:0]      sum_wide;

	logic [SUM_W-1:0]    fitness_q;
	logic [GCOUNT_W-1:0] counted_q;
	logic [ERR_W-1:0]    code_q;

	// Element count saturated at the matrix size
	assign n_eff = (32'(element_count_q) > 32'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS)
	                                                          : element_count_q;

	// Checks on the presented gene
	assign in_oor  = {1'b0, gene} >= n_eff;
	assign in_full = 32'(gene_total_q) >= 32'(MAX_GENES);

	always_comb begin
		status.in_gene   = (command == CMD_GENE);
		status.in_pairs  = !in_oor && !in_full && (gene_total_q != '0);
		status.pair_last = (CW'(pair_idx) + CW'(1)) == gene_total_q;
		status.last      = last_q;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= ELEM_COUNT_RESET;
		end else if (cfg_we) begin
			element_count_q <= cfg_data;
		end
	end

	// Distance store write on a load transfer
	assign load_addr = 32'(dist_address);

	always_ff @(posedge clk) begin
		if (cmd.capture && (command == CMD_LOAD) && (load_addr < 32'(DIST_DEPTH))) begin
			dist_mem[load_addr[AW-1:0]] <= dist_value;
		end
	end

	// Capture the gene and its error code
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gene_q <= gene;
			last_q <= last;
			priority if (in_oor) begin
				err_q <= ERR_RANGE;
			end else if (in_full) begin
				err_q <= ERR_FULL;
			end else begin
				err_q <= ERR_NONE;
			end
		end
	end

	// Gene store: append on commit, read one entry per pair
	always_ff @(posedge clk) begin
		if (cmd.commit && (err_q == ERR_NONE)) begin
			gene_mem[gene_total_q[GW-1:0]] <= gene_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			stored_s1 <= gene_mem[pair_idx];
		end
	end

	// Order the pair and form the index terms
	assign lo = (stored_s1 < gene_q) ? stored_s1 : gene_q;
	assign hi = (stored_s1 < gene_q) ? gene_q : stored_s1;

	always_ff @(posedge clk) begin
		same_s2   <= (stored_s1 == gene_q);
		prod_a_s2 <= PROD_W'(lo) * PROD_W'(n_eff);
		prod_b_s2 <= PROD_W'(lo) * (PROD_W'(lo) + PROD_W'(1));
		diff_s2   <= hi - lo - GENE_W'(1);
	end

	// Packed index; the top bit flags a negative value
	assign idx     = IDX_W'(prod_a_s2) - IDX_W'(prod_b_s2[PROD_W-1:1]) + IDX_W'(diff_s2);
	assign idx_ext = 32'(idx[IDX_W-2:0]);
	assign idx_ok  = !idx[IDX_W-1] && (idx_ext < 32'(DIST_DEPTH));

	always_ff @(posedge clk) begin
		use_s3 <= !same_s2 && idx_ok;
		if (valid_s2 && idx_ok) begin
			dist_s3 <= dist_mem[idx_ext[AW-1:0]];
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Saturating accumulate
	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(use_s3 ? dist_s3 : '0);

	// Subset state: sum, count and first error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			gene_total_q <= '0;
			err_flags_q  <= ERR_NONE;
		end else if (cmd.emit) begin
			sum_q        <= '0;
			gene_total_q <= '0;
			err_flags_q  <= ERR_NONE;
		end else begin
			if (valid_s3) begin
				sum_q <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
			end
			if (cmd.commit) begin
				if (err_q == ERR_NONE) begin
					gene_total_q <= gene_total_q + CW'(1);
				end else if (err_flags_q == ERR_NONE) begin
					err_flags_q <= err_q;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fitness_q <= sum_q;
			counted_q <= GCOUNT_W'(gene_total_q);
			code_q    <= err_flags_q;
		end
	end

	assign fitness_sum   = fitness_q;
	assign genes_counted = counted_q;
	assign error_code    = code_q;

endmodule

### src/pairwise_distance_sum_top.sv
// Top level of the pairwise distance sum block: controller and datapath.
`timescale 1ns / 1ps

// Fitness evaluation for the maximum diversity problem. Load commands write one
// Q16.16 distance word of the packed upper triangle per transfer. Gene commands
// add each new gene's distances to every earlier gene of the subset; the gene
// marked last returns the Q32.16 sum, the gene count and the first error, then
// clears the subset. A gene that meets k stored genes holds the input through
// one distance store read per pair, then the drain of the index and read
// pipeline, then a commit step, plus a result step if marked last. A gene that
// is rejected or has no earlier genes goes straight from capture to commit. The
// result register lets the next transfer in while a result waits. Neither store
// is cleared after reset, so no clearing pass runs; element_count resets to 256;
// the user must write it only while the block is idle, which is not enforced.

module pairwise_distance_sum_top import pds_pkg::*; #(
	parameter int MAX_ELEMENTS = PDS_MAX_ELEMENTS,
	parameter int MAX_GENES    = PDS_MAX_GENES,
	parameter int DIST_DEPTH   = PDS_DIST_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [ADDR_W-1:0]   dist_address,
	input  logic [DIST_W-1:0]   dist_value,
	input  logic [GENE_W-1:0]   gene,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SUM_W-1:0]    fitness_sum,
	output logic [GCOUNT_W-1:0] genes_counted,
	output logic [ERR_W-1:0]    error_code
);

	localparam int GW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;

	pds_cmd_t      cmd;
	pds_status_t   status;
	logic [GW-1:0] pair_idx;

	pds_ctrl #(
		.MAX_GENES (MAX_GENES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd),
		.pair_idx  (pair_idx)
	);

	pds_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.MAX_GENES    (MAX_GENES),
		.DIST_DEPTH   (DIST_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.command       (command),
		.dist_address  (dist_address),
		.dist_value    (dist_value),
		.gene          (gene),
		.last          (last),
		.cmd           (cmd),
		.pair_idx      (pair_idx),
		.status        (status),
		.fitness_sum   (fitness_sum),
		.genes_counted (genes_counted),
		.error_code    (error_code)
	);

endmodule

### src/pds_checker.sv
// Port-level checker for the pairwise distance sum block and its bind.
`timescale 1ns / 1ps

module pds_checker import pds_pkg::*; #(
	parameter int MAX_GENES = PDS_MAX_GENES
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SUM_W-1:0]    fitness_sum,
	input logic [GCOUNT_W-1:0] genes_counted,
	input logic [ERR_W-1:0]    error_code
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fitness_sum))
		else $error("result dropped or changed while stalled");

	// Report only defined error codes
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE) || (error_code == ERR_FULL) ||
		              (error_code == ERR_RANGE))
		else $error("undefined error code");

	// A full store error comes only with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_FULL) |-> genes_counted == GCOUNT_W'(MAX_GENES))
		else $error("full store error with partial gene count");

	// Fewer than two genes form no pair
	a_no_pair_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (MAX_GENES < 128) && (genes_counted < GCOUNT_W'(2)) |->
		fitness_sum == '0)
		else $error("nonzero sum without any pair");

endmodule

bind pairwise_distance_sum_top pds_checker #(.MAX_GENES(MAX_GENES)) u_pds_checker (.*);

### dv/tb.sv
// Testbench of the pairwise distance sum block: driver, monitor and scoring predictor.
`timescale 1ns / 1ps

module tb;
	import pds_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 70;
	localparam int PHASES        = 8;
	localparam int ADDR_SPAN     = (1 << ADDR_W) - 1;
	localparam logic [SUM_W-1:0] SUM_CEIL = '1;

	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [DIST_W-1:0] value;
		logic [GENE_W-1:0] gene;
		logic              last;
	} subset_cmd_t;

	typedef struct {
		logic [SUM_W-1:0]    sum;
		logic [GCOUNT_W-1:0] count;
		logic [ERR_W-1:0]    err;
	} fitness_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                cfg_we   = 1'b0;
	logic [COUNT_W-1:0]  cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                command      = CMD_LOAD;
	logic [ADDR_W-1:0]   dist_address = '0;
	logic [DIST_W-1:0]   dist_value   = '0;
	logic [GENE_W-1:0]   gene         = '0;
	logic                last         = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [SUM_W-1:0]    fitness_sum;
	logic [GCOUNT_W-1:0] genes_counted;
	logic [ERR_W-1:0]    error_code;

	// Stimulus side
	subset_cmd_t cmd_backlog[$];
	subset_cmd_t drv_cmd;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          stim_n;
	bit          stim_written [PDS_DIST_DEPTH];
	int          subset_genes[$];
	int          cmds_queued    = 0;
	int          subsets_queued = 0;

	// Predictor side
	logic [DIST_W-1:0]  score_dist [PDS_DIST_DEPTH];
	int                 score_genes [PDS_MAX_GENES];
	int                 score_total;
	logic [SUM_W-1:0]   score_sum;
	logic [ERR_W-1:0]   score_err;
	logic [COUNT_W-1:0] score_count;
	fitness_t           expected_scores[$];

	int fault_count   = 0;
	int results_seen  = 0;
	int err_tally [4] = '{0, 0, 0, 0};
	int quiet_cycles  = 0;
	int phase_cfg [PHASES] = '{2, 511, 256, 1, 100, 0, 255, 3};

	pairwise_distance_sum_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.dist_address (dist_address),
		.dist_value   (dist_value),
		.gene         (gene),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fitness_sum  (fitness_sum),
		.genes_counted(genes_counted),
		.error_code   (error_code)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Packed upper-triangle position of the pair (a, b), a != b
	function automatic int tri_index(input int a, input int b, input int n);
		int lo;
		int hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return lo * n - (lo * (lo + 1)) / 2 + (hi - lo - 1);
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Score one accepted transfer; queue a result when it closes a subset
	task automatic score_transfer(input subset_cmd_t c);
		int          n;
		int          idx;
		logic [SUM_W:0] acc;
		fitness_t    res;
		n = (score_count > PDS_MAX_ELEMENTS) ? PDS_MAX_ELEMENTS : int'(score_count);
		if (c.cmd == CMD_LOAD) begin
			if (c.addr < PDS_DIST_DEPTH)
				score_dist[c.addr] = c.value;
		end else begin
			if (int'(c.gene) >= n) begin
				if (score_err == ERR_NONE)
					score_err = ERR_RANGE;
			end else if (score_total >= PDS_MAX_GENES) begin
				if (score_err == ERR_NONE)
					score_err = ERR_FULL;
			end else begin
				for (int k = 0; k < score_total; k++) begin
					if (score_genes[k] != int'(c.gene)) begin
						idx = tri_index(score_genes[k], c.gene, n);
						if (idx < PDS_DIST_DEPTH) begin
							acc = {1'b0, score_sum} + (SUM_W + 1)'(score_dist[idx]);
							score_sum = acc[SUM_W] ? SUM_CEIL : acc[SUM_W-1:0];
						end
					end
				end
				score_genes[score_total] = c.gene;
				score_total++;
			end
			if (c.last) begin
				res.sum   = score_sum;
				res.count = GCOUNT_W'(score_total);
				res.err   = score_err;
				expected_scores.push_back(res);
				score_total = 0;
				score_sum   = '0;
				score_err   = ERR_NONE;
			end
		end
	endtask

	task automatic push_load(input int addr, input logic [DIST_W-1:0] value);
		subset_cmd_t c;
		c.cmd   = CMD_LOAD;
		c.addr  = ADDR_W'(addr);
		c.value = value;
		c.gene  = GENE_W'($urandom);
		c.last  = 1'($urandom);
		cmd_backlog.push_back(c);
		if (addr < PDS_DIST_DEPTH)
			stim_written[addr] = 1'b1;
		cmds_queued++;
	endtask

	// Load every distance the subset will read, then queue its genes
	task automatic push_subset(input bit noisy);
		int          kept[$];
		int          g;
		int          idx;
		subset_cmd_t c;
		foreach (subset_genes[i]) begin
			g = subset_genes[i];
			if (g < stim_n && kept.size() < PDS_MAX_GENES) begin
				foreach (kept[k]) begin
					if (kept[k] != g) begin
						idx = tri_index(kept[k], g, stim_n);
						if (!stim_written[idx])
							push_load(idx, pick_distance());
					end
				end
				kept.push_back(g);
			end
		end
		foreach (subset_genes[i]) begin
			// drop a stray load into the middle of the subset now and then
			if (noisy && $urandom_range(19) == 0)
				push_load($urandom_range(1) ? $urandom_range(ADDR_SPAN, PDS_DIST_DEPTH)
					: $urandom_range(ADDR_SPAN), pick_distance());
			c.cmd   = CMD_GENE;
			c.addr  = ADDR_W'($urandom);
			c.value = $urandom;
			c.gene  = GENE_W'(subset_genes[i]);
			c.last  = (i == subset_genes.size() - 1);
			cmd_backlog.push_back(c);
			cmds_queued++;
		end
		subsets_queued++;
	endtask

	// Random subsets: mostly short, some long enough to overflow the gene store
	task automatic plan_random_phase(input int budget);
		int start;
		int len;
		int pool_sz;
		int bad_pct;
		int pool[$];
		start = cmds_queued;
		while (cmds_queued - start < budget) begin
			if ($urandom_range(11) == 0) begin
				len     = $urandom_range(PDS_MAX_GENES + 8, PDS_MAX_GENES - 2);
				pool_sz = $urandom_range(4, 1);
				bad_pct = 2;
			end else begin
				len     = $urandom_range(8, 1);
				pool_sz = $urandom_range(len, 1);
				bad_pct = 12;
			end
			pool.delete();
			for (int i = 0; i < pool_sz; i++) begin
				if (stim_n == 0)
					pool.push_back(0);
				else if ($urandom_range(3) == 0)
					pool.push_back($urandom_range(1) ? 0 : stim_n - 1);
				else
					pool.push_back($urandom_range(stim_n - 1));
			end
			subset_genes.delete();
			for (int i = 0; i < len; i++) begin
				if (stim_n == 0 || (stim_n < PDS_MAX_ELEMENTS && $urandom_range(99) < bad_pct))
					subset_genes.push_back($urandom_range(255, stim_n));
				else
					subset_genes.push_back(pool[$urandom_range(pool.size() - 1)]);
			end
			push_subset(1'b1);
		end
	endtask

	// Hold off until the block has drained, then let it go quiet
	task automatic settle();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || expected_scores.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		stim_n = (value > PDS_MAX_ELEMENTS) ? PDS_MAX_ELEMENTS : int'(value);
		@(negedge clk);
	endtask

	// Driver: present the next command once the current one has transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_cmd = cmd_backlog.pop_front();
					command      <= drv_cmd.cmd;
					dist_address <= drv_cmd.addr;
					dist_value   <= drv_cmd.value;
					gene         <= drv_cmd.gene;
					last         <= drv_cmd.last;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: track configuration, score input transfers, check result transfers
	always @(posedge clk) begin
		fitness_t want;
		if (!arst_n) begin
			score_total = 0;
			score_sum   = '0;
			score_err   = ERR_NONE;
			score_count = ELEM_COUNT_RESET;
		end else begin
			if (cfg_we)
				score_count = cfg_data;
			if (in_valid && in_ready)
				score_transfer('{command, dist_address, dist_value, gene, last});
			if (out_valid && out_ready) begin
				results_seen++;
				err_tally[error_code]++;
				if (expected_scores.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result: sum %h count %0d err %0d",
							fitness_sum, genes_counted, error_code);
				end else begin
					want = expected_scores.pop_front();
					if (fitness_sum !== want.sum || genes_counted !== want.count
							|| error_code !== want.err) begin
						fault_count++;
						if (fault_count <= 10)
							$display("result %0d: sum %h/%h count %0d/%0d err %0d/%0d (exp/act)",
								results_seen, want.sum, fitness_sum, want.count,
								genes_counted, want.err, error_code);
					end
				end
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_n = ELEM_COUNT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme values and addresses, ignored load, repeats, lone gene
		push_load(0, '1);
		push_load(PDS_DIST_DEPTH - 1, 32'h0001_0000);
		push_load(ADDR_SPAN, 32'h1234_5678);
		push_load(1, 32'h8000_0000);
		push_load(tri_index(1, 2, stim_n), 32'h0000_0001);
		subset_genes = '{0, 1, 2};
		push_subset(1'b0);
		subset_genes = '{255, 254};
		push_subset(1'b0);
		subset_genes = '{9};
		push_subset(1'b0);
		subset_genes = '{7, 7, 7};
		push_subset(1'b0);
		subset_genes = '{0, 255, 128};
		push_subset(1'b0);
		settle();

		// Random phases, each with its own element count and one of four idling patterns
		for (int p = 0; p < PHASES; p++) begin
			write_count(COUNT_W'(phase_cfg[p]));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			if (p == 0) begin
				subset_genes = '{1, 0, 5, 1, 200};
				push_subset(1'b0);
			end
			plan_random_phase(PHASE_ITEMS);
			settle();
		end

		$display("covered %0d commands in %0d subsets over %0d element counts",
			cmds_queued, subsets_queued, PHASES + 1);
		$display("checked %0d results: %0d clean, %0d store full, %0d out of range",
			results_seen, err_tally[ERR_NONE], err_tally[ERR_FULL], err_tally[ERR_RANGE]);
		if (fault_count == 0 && expected_scores.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("%0d mismatches, %0d results missing", fault_count,
				expected_scores.size());
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
